FILE: hdl/c_type_keyword_lexer_top_assert.svh
// Assertion macros shared by the lexer modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef C_TYPE_KEYWORD_LEXER_TOP_ASSERT_SVH
`define C_TYPE_KEYWORD_LEXER_TOP_ASSERT_SVH

`ifndef SYNTH
`define CTKL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");
`define CTKL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");
`else
`define CTKL_ASSERT_IMPLIES(lbl, ante, cons)
`define CTKL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/ctkl_pkg.sv
`default_nettype none
package ctkl_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int KW_CHARS    = 8;
  localparam int KW_IDX_W    = $clog2(KW_CHARS);
  localparam int OFS_W       = 16;
  localparam int KW_COUNT    = 19;

  localparam logic [OFS_W-1:0] POS_LIMIT =
    (OFFSET_BITS >= OFS_W) ? {OFS_W{1'b1}} : OFS_W'((64'd1 << OFFSET_BITS) - 64'd1);

  typedef enum logic [4:0] {
    KIND_INVALID  = 5'd0,
    KIND_BOOL     = 5'd1,
    KIND_CHAR     = 5'd2,
    KIND_SHORT    = 5'd3,
    KIND_INT      = 5'd4,
    KIND_LONG     = 5'd5,
    KIND_FLOAT    = 5'd6,
    KIND_DOUBLE   = 5'd7,
    KIND_STRUCT   = 5'd8,
    KIND_ENUM     = 5'd9,
    KIND_UNION    = 5'd10,
    KIND_IDENT    = 5'd11,
    KIND_SIGNED   = 5'd12,
    KIND_UNSIGNED = 5'd13,
    KIND_COMPLEX  = 5'd14,
    KIND_CONST    = 5'd15,
    KIND_VOLATILE = 5'd16,
    KIND_RESTRICT = 5'd17,
    KIND_VOID     = 5'd18,
    KIND_POINTER  = 5'd19,
    KIND_END      = 5'd20
  } kind_t;

  // Element 0 is the first character of the word.
  typedef logic [0:KW_CHARS-1][7:0] chars_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [4:0]       token_kind;
    logic [OFS_W-1:0] token_start;
    logic [OFS_W-1:0] token_length;
    logic             final_of_run;
  } out_word_t;

  typedef struct packed {
    logic [4:0]       kind;
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] length;
  } tok_t;

  // Up to three tokens produced by one byte, packed from slot 0 upward.
  typedef struct packed {
    tok_t [2:0] slot;
    logic [1:0] count;
  } bundle_t;

  typedef struct packed {
    chars_t     text;
    logic [3:0] len;
    kind_t      kind;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{{"bool", 32'h0},     4'd4, KIND_BOOL},
    '{{"char", 32'h0},     4'd4, KIND_CHAR},
    '{{"short", 24'h0},    4'd5, KIND_SHORT},
    '{{"int", 40'h0},      4'd3, KIND_INT},
    '{{"long", 32'h0},     4'd4, KIND_LONG},
    '{{"float", 24'h0},    4'd5, KIND_FLOAT},
    '{{"double", 16'h0},   4'd6, KIND_DOUBLE},
    '{{"struct", 16'h0},   4'd6, KIND_STRUCT},
    '{{"enum", 32'h0},     4'd4, KIND_ENUM},
    '{{"union", 24'h0},    4'd5, KIND_UNION},
    '{{"signed", 16'h0},   4'd6, KIND_SIGNED},
    '{"unsigned",          4'd8, KIND_UNSIGNED},
    '{{"complex", 8'h0},   4'd7, KIND_COMPLEX},
    '{{"const", 24'h0},    4'd5, KIND_CONST},
    '{"volatile",          4'd8, KIND_VOLATILE},
    '{"restrict",          4'd8, KIND_RESTRICT},
    '{{"void", 32'h0},     4'd4, KIND_VOID},
    '{{"_Bool", 24'h0},    4'd5, KIND_BOOL},
    '{"_Complex",          4'd8, KIND_COMPLEX}
  };

  function automatic logic [OFS_W-1:0] sat_inc(input logic [OFS_W-1:0] x);
    return (x < POS_LIMIT) ? x + OFS_W'(1) : POS_LIMIT;
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_word_start(c) || ((c >= "0") && (c <= "9"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Characters past the word length are always zero, so a padded compare
  // together with the length check gives an exact match.
  function automatic kind_t kw_kind(input chars_t text, input logic [OFS_W-1:0] len);
    kind_t k;
    k = KIND_IDENT;
    if (len <= OFS_W'(KW_CHARS)) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if ((len == OFS_W'(KW_TABLE[i].len)) && (text == KW_TABLE[i].text)) begin
          k = KW_TABLE[i].kind;
        end
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ctkl_scan.sv
`default_nettype none
`include "c_type_keyword_lexer_top_assert.svh"
module ctkl_scan (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire ctkl_pkg::in_word_t in_data,
  output ctkl_pkg::bundle_t       bundle
);
  import ctkl_pkg::*;

  chars_t           chars_r, chars_nxt;
  logic [OFS_W-1:0] len_r, len_nxt;
  logic             inside_r, inside_nxt;
  logic [OFS_W-1:0] begin_r, begin_nxt;
  logic [OFS_W-1:0] pos_r, pos_nxt;

  logic [7:0] c;
  logic       last;
  tok_t [3:0] cand;
  logic [3:0] cand_v;
  logic [1:0] cnt;

  assign c    = in_data.text_byte;
  assign last = in_data.end_of_text;

  always_comb begin
    chars_nxt  = chars_r;
    len_nxt    = len_r;
    inside_nxt = inside_r;
    begin_nxt  = begin_r;
    pos_nxt    = sat_inc(pos_r);
    cand_v     = '0;
    if (inside_r && is_word_char(c)) begin
      if (len_r < OFS_W'(KW_CHARS)) begin
        chars_nxt[len_r[KW_IDX_W-1:0]] = c;
      end
      len_nxt = sat_inc(len_r);
    end else begin
      cand_v[0]  = inside_r;
      inside_nxt = 1'b0;
      if (is_word_start(c)) begin
        inside_nxt   = 1'b1;
        begin_nxt    = pos_r;
        chars_nxt    = '0;
        chars_nxt[0] = c;
        len_nxt      = OFS_W'(1);
      end else if (!is_space(c)) begin
        cand_v[1] = 1'b1;
      end
    end
    cand_v[2] = last && inside_nxt;
    cand_v[3] = last;

    // Word closed by this byte, the byte's own token, the word closed by the
    // end of text, and the end marker.
    cand[0] = '{kind: kw_kind(chars_r, len_r), start: begin_r, length: len_r};
    cand[1] = '{kind: ((c == "*") ? KIND_POINTER : KIND_INVALID), start: pos_r,
                length: OFS_W'(1)};
    cand[2] = '{kind: kw_kind(chars_nxt, len_nxt), start: begin_nxt, length: len_nxt};
    cand[3] = '{kind: KIND_END, start: pos_nxt, length: '0};

    bundle = '0;
    cnt    = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        bundle.slot[cnt] = cand[i];
        cnt              = cnt + 2'd1;
      end
    end
    bundle.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r  <= '0;
      len_r    <= '0;
      inside_r <= 1'b0;
      begin_r  <= '0;
      pos_r    <= '0;
    end else if (go) begin
      if (last) begin
        chars_r  <= '0;
        len_r    <= '0;
        inside_r <= 1'b0;
        begin_r  <= '0;
        pos_r    <= '0;
      end else begin
        chars_r  <= chars_nxt;
        len_r    <= len_nxt;
        inside_r <= inside_nxt;
        begin_r  <= begin_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  `CTKL_ASSERT_NEXT(a_reset_after_last, go && last, !inside_r && (pos_r == '0))
  `CTKL_ASSERT_IMPLIES(a_word_has_length, inside_r, len_r != '0)
  `CTKL_ASSERT_IMPLIES(a_word_not_ahead, inside_r, begin_r <= pos_r)

endmodule
`default_nettype wire

FILE: hdl/ctkl_emit.sv
`default_nettype none
`include "c_type_keyword_lexer_top_assert.svh"
module ctkl_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire ctkl_pkg::bundle_t   bundle,
  output logic                     bnd_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctkl_pkg::out_word_t      out_data
);
  import ctkl_pkg::*;

  tok_t [2:0] slot_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       last_slot;
  logic       fire;

  assign last_slot = (idx_r == (cnt_r - 2'd1));
  assign fire      = valid_r && !out_stall;
  // The bundle register frees up in the same cycle its final word leaves.
  assign bnd_ready = !valid_r || (fire && last_slot);

  assign out_valid             = valid_r;
  assign out_data.token_kind   = slot_r[idx_r].kind;
  assign out_data.token_start  = slot_r[idx_r].start;
  assign out_data.token_length = slot_r[idx_r].length;
  assign out_data.final_of_run = last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
      cnt_r   <= bundle.count;
    end else if (fire) begin
      if (last_slot) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle.slot;
    end
  end

  `CTKL_ASSERT_IMPLIES(a_load_when_free, load, bnd_ready && (bundle.count != 2'd0))
  `CTKL_ASSERT_IMPLIES(a_idx_in_range, valid_r, (idx_r < cnt_r) && (cnt_r != 2'd0))
  `CTKL_ASSERT_NEXT(a_run_continues, fire && !last_slot,
                    valid_r && (idx_r == ($past(idx_r) + 2'd1)))

endmodule
`default_nettype wire

FILE: hdl/c_type_keyword_lexer_top.sv
// A byte accepted into byte_r is scanned there and its tokens are registered in
// the slot register of u_emit; a byte with no token just updates the lexer state.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is not stalled; a byte's tokens leave the output register one at a time.
// Reset (rst_n low, synchronous) clears the lexer state and all valid flags.
`default_nettype none
module c_type_keyword_lexer_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ctkl_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ctkl_pkg::out_word_t      out_data
);
  import ctkl_pkg::*;

  in_word_t byte_r;
  logic     hold_r;
  logic     bnd_ready;
  logic     go;
  logic     load;
  bundle_t  bundle;

  assign go       = hold_r && bnd_ready;
  assign load     = go && (bundle.count != 2'd0);
  assign in_stall = hold_r && !bnd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_r <= 1'b1;
    end else if (go) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data;
    end
  end

  ctkl_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .in_data (byte_r),
    .bundle  (bundle)
  );

  ctkl_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .bnd_ready (bnd_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
